@@ design/rsp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and defaults for the RESP stream parser.
// Depends on nothing; every other design file imports it.
package rsp_pkg;

	localparam int MAX_DEPTH_DEF  = 16;
	localparam int COUNT_BITS_DEF = 32;

	// event codes
	localparam logic [2:0] EV_IGNORE = 3'd0;
	localparam logic [2:0] EV_FRAME  = 3'd1;
	localparam logic [2:0] EV_DATA   = 3'd2;
	localparam logic [2:0] EV_VALUE  = 3'd3;
	localparam logic [2:0] EV_ERROR  = 3'd4;

	// value kinds
	localparam logic [2:0] K_INT   = 3'd0;
	localparam logic [2:0] K_STR   = 3'd1;
	localparam logic [2:0] K_ERR   = 3'd2;
	localparam logic [2:0] K_BULK  = 3'd3;
	localparam logic [2:0] K_NULL  = 3'd4;
	localparam logic [2:0] K_ARRAY = 3'd5;

	// error codes
	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_TOKEN    = 3'd1;
	localparam logic [2:0] E_MARKER   = 3'd2;
	localparam logic [2:0] E_DEEP     = 3'd3;
	localparam logic [2:0] E_OVERFLOW = 3'd4;

	// stream characters
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// strtoll style magnitude limits
	localparam logic [63:0] INT_POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT_NEG_LIM = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		PH_MARK,
		PH_INT_START,
		PH_INT_BODY,
		PH_COUNT,
		PH_STR,
		PH_NUL_CR,
		PH_LINE_LF,
		PH_BULK_DATA,
		PH_BULK_CR,
		PH_BULK_LF,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic en;
		logic clear;
		logic push;
		logic close;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic empty_close;
	} stk_stat_t;

endpackage

@@ design/rsp_digit.sv @@
`timescale 1ns / 1ps
// Decimal digit step: accum * 10 + digit with a limit compare.
// Depends on rsp_pkg for the character codes.
module rsp_digit (
	input  logic [7:0]  data,
	input  logic [63:0] acc,
	input  logic [63:0] lim,
	output logic        is_digit,
	output logic [63:0] acc_next,
	output logic        over
);
	import rsp_pkg::*;

	logic [3:0]  dval;
	logic [67:0] prod;

	assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
	assign dval     = 4'(data - CH_ZERO);
	assign prod     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {64'b0, dval};
	assign over     = prod > {4'b0, lim};
	assign acc_next = prod[63:0];

endmodule

@@ design/rsp_stack.sv @@
`timescale 1ns / 1ps
// Array nesting stack: element counts still owed per level, with the
// cascade of closing arrays resolved in one step. Depends on rsp_pkg.
module rsp_stack #(
	parameter int MAX_DEPTH  = rsp_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_BITS = rsp_pkg::COUNT_BITS_DEF,
	localparam int PTR_W     = $clog2(MAX_DEPTH + 1),
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsp_pkg::stk_cmd_t     cmd,
	input  logic [COUNT_BITS-1:0] push_val,
	output logic [PTR_W-1:0]      depth,
	output rsp_pkg::stk_stat_t    stat
);
	import rsp_pkg::*;

	logic [PTR_W-1:0]      ptr_q;
	logic [PTR_W-1:0]      ptr_n;
	logic [COUNT_BITS-1:0] cnt_q [MAX_DEPTH];
	logic                  one_q [MAX_DEPTH];
	logic                  found;
	logic [IDX_W-1:0]      sel;
	logic [IDX_W-1:0]      pidx;

	assign depth = cmd.clear ? '0 : ptr_q;
	assign pidx  = depth[IDX_W-1:0];

	// innermost open level that survives a close: its count is not one
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((PTR_W'(i) < depth) && !one_q[i]) begin
				found = 1'b1;
				sel   = IDX_W'(i);
			end
		end
	end

	assign stat.full        = depth >= PTR_W'(MAX_DEPTH);
	assign stat.empty_close = !found;

	always_comb begin
		ptr_n = depth;
		if (cmd.push) begin
			ptr_n = depth + PTR_W'(1);
		end else if (cmd.close) begin
			ptr_n = found ? (PTR_W'(sel) + PTR_W'(1)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.en) begin
			ptr_q <= ptr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && cmd.push) begin
			cnt_q[pidx] <= push_val;
			one_q[pidx] <= push_val == COUNT_BITS'(1);
		end else if (cmd.en && cmd.close && found) begin
			cnt_q[sel] <= cnt_q[sel] - COUNT_BITS'(1);
			one_q[sel] <= cnt_q[sel] == COUNT_BITS'(2);
		end
	end

endmodule

@@ design/resp_stream_parser.sv @@
`timescale 1ns / 1ps
// RESP stream parser top level: input register, parse step, result register.
// Depends on rsp_pkg, rsp_digit and rsp_stack.
//
// Usage:
//   Feed the RESP stream one byte per item on the s_ group; raise s_tuser
//   with the first byte of each message to drop any partial parse, the
//   nesting stack, the byte offset and a latched error.
//   Every accepted byte yields exactly one result item on the m_ group that
//   classifies it (ignored, framing, payload, value finished, error) along
//   with kind, payload byte, finished number, nesting depth, error code and
//   byte offset. m_tlast marks the byte that completes the top-level value.
//   Throughput: one item per cycle while the receiver keeps m_tready high;
//   the parse step is a single registered pass, and array closes of any
//   depth settle in that pass. Each accepted item sits in the input
//   register, then moves to the result register, which drives m_tvalid.
//   Stalls: when m_tready is low the result register holds; the input
//   register still takes one more item, after which s_tready drops until
//   the result is taken.
//   Reset: arst_n clears both registers' valid flags and all parse state;
//   the first byte after reset is at offset zero.
//   Errors latch: later bytes are reported as ignored with the latched code
//   until a new message is started.
module resp_stream_parser #(
	parameter int MAX_DEPTH  = rsp_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_BITS = rsp_pkg::COUNT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] data_byte
	input  logic [0:0]   s_tuser,  // [0] start_req
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // [7:0] payload, [71:8] number, [76:72] depth,
	                               // [79:77] error_code, [111:80] offset
	output logic [5:0]   m_tuser,  // [2:0] event_res, [5:3] kind
	output logic         m_tlast   // message_done
);
	import rsp_pkg::*;

	localparam int PTR_W = $clog2(MAX_DEPTH + 1);
	localparam logic [63:0] COUNT_MAX = 64'((65'(1) << COUNT_BITS) - 65'(1));

	// handshake
	logic adv;
	logic valid_s1, valid_s2;
	logic [7:0] data_s1;
	logic start_s1;

	// parse state
	phase_t phase_q, phase_n, ph_c;
	logic [2:0]            kind_q, kind_c, kind_n;
	logic [63:0]           acc_q, acc_c, acc_n;
	logic                  neg_q, neg_c, neg_n;
	logic                  dig_q, dig_c, dig_n;
	logic [COUNT_BITS-1:0] bulk_q, bulk_c, bulk_n;
	logic [31:0]           off_q, off_c;
	logic                  err_q, err_c, err_n;
	logic [2:0]            ecode_q, ecode_c, ecode_n;

	// step results
	logic [2:0]         ev;
	logic [2:0]         res_code;
	logic [7:0]         res_payload;
	logic signed [63:0] res_number;
	logic               res_done;
	logic [2:0]         res_kind;

	// result register
	logic [2:0]         ev_s2, kind_s2, code_s2;
	logic [7:0]         payload_s2;
	logic signed [63:0] number_s2;
	logic [4:0]         depth_s2;
	logic               done_s2;
	logic [31:0]        off_s2;

	// helpers
	logic [63:0]      lim;
	logic             is_digit, over;
	logic [63:0]      acc_next;
	stk_cmd_t         stk_cmd;
	stk_stat_t        stk_stat;
	logic [PTR_W-1:0] stk_depth;

	// advance the step when the result register is free or being emptied
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	// state as seen by this byte: a start drops everything first
	always_comb begin
		ph_c    = start_s1 ? PH_MARK : phase_q;
		kind_c  = start_s1 ? K_INT : kind_q;
		acc_c   = start_s1 ? '0 : acc_q;
		neg_c   = start_s1 ? 1'b0 : neg_q;
		dig_c   = start_s1 ? 1'b0 : dig_q;
		bulk_c  = start_s1 ? '0 : bulk_q;
		off_c   = start_s1 ? '0 : off_q;
		err_c   = start_s1 ? 1'b0 : err_q;
		ecode_c = start_s1 ? E_NONE : ecode_q;
	end

	assign lim = (ph_c == PH_COUNT) ? COUNT_MAX : (neg_c ? INT_NEG_LIM : INT_POS_LIM);

	rsp_digit u_digit (
		.data     (data_s1),
		.acc      (acc_c),
		.lim      (lim),
		.is_digit (is_digit),
		.acc_next (acc_next),
		.over     (over)
	);

	rsp_stack #(
		.MAX_DEPTH  (MAX_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (stk_cmd),
		.push_val (acc_c[COUNT_BITS-1:0]),
		.depth    (stk_depth),
		.stat     (stk_stat)
	);

	// parse step: next state and the result of this byte
	always_comb begin
		phase_n       = ph_c;
		kind_n        = kind_c;
		acc_n         = acc_c;
		neg_n         = neg_c;
		dig_n         = dig_c;
		bulk_n        = bulk_c;
		err_n         = err_c;
		ecode_n       = ecode_c;
		ev            = EV_FRAME;
		res_code      = E_NONE;
		res_payload   = 8'd0;
		res_number    = 64'sd0;
		res_done      = 1'b0;
		stk_cmd.en    = adv;
		stk_cmd.clear = start_s1;
		stk_cmd.push  = 1'b0;
		stk_cmd.close = 1'b0;

		if (err_c) begin
			ev       = EV_IGNORE;
			res_code = ecode_c;
		end else begin
			case (ph_c)
				PH_MARK: begin
					acc_n = '0;
					neg_n = 1'b0;
					dig_n = 1'b0;
					case (data_s1)
						CH_COLON: begin
							kind_n  = K_INT;
							phase_n = PH_INT_START;
						end
						CH_PLUS: begin
							kind_n  = K_STR;
							phase_n = PH_STR;
						end
						CH_MINUS: begin
							kind_n  = K_ERR;
							phase_n = PH_STR;
						end
						CH_DOLLAR: begin
							kind_n  = K_BULK;
							phase_n = PH_COUNT;
						end
						CH_USCORE: begin
							kind_n  = K_NULL;
							phase_n = PH_NUL_CR;
						end
						CH_STAR: begin
							kind_n  = K_ARRAY;
							phase_n = PH_COUNT;
						end
						default: begin
							ev       = EV_ERROR;
							res_code = E_MARKER;
						end
					endcase
				end
				PH_INT_START, PH_INT_BODY: begin
					if ((ph_c == PH_INT_START) &&
					    ((data_s1 == CH_PLUS) || (data_s1 == CH_MINUS))) begin
						neg_n   = data_s1 == CH_MINUS;
						phase_n = PH_INT_BODY;
					end else if (is_digit) begin
						// saturate like strtoll, keep taking digits
						acc_n   = over ? lim : acc_next;
						dig_n   = 1'b1;
						phase_n = PH_INT_BODY;
					end else if ((data_s1 == CH_CR) && ((ph_c == PH_INT_START) || dig_c)) begin
						phase_n = PH_LINE_LF;
					end else begin
						ev       = EV_ERROR;
						res_code = E_TOKEN;
					end
				end
				PH_COUNT: begin
					if (is_digit) begin
						if (over) begin
							ev       = EV_ERROR;
							res_code = E_OVERFLOW;
						end else begin
							acc_n = acc_next;
						end
					end else if (data_s1 == CH_CR) begin
						phase_n = PH_LINE_LF;
					end else begin
						ev       = EV_ERROR;
						res_code = E_TOKEN;
					end
				end
				PH_STR: begin
					if (data_s1 == CH_CR) begin
						phase_n = PH_LINE_LF;
					end else if (data_s1 == CH_LF) begin
						ev       = EV_ERROR;
						res_code = E_TOKEN;
					end else begin
						ev          = EV_DATA;
						res_payload = data_s1;
					end
				end
				PH_NUL_CR, PH_BULK_CR: begin
					if (data_s1 == CH_CR) begin
						phase_n = (ph_c == PH_NUL_CR) ? PH_LINE_LF : PH_BULK_LF;
					end else begin
						ev       = EV_ERROR;
						res_code = E_TOKEN;
					end
				end
				PH_BULK_DATA: begin
					ev          = EV_DATA;
					res_payload = data_s1;
					bulk_n      = bulk_c - COUNT_BITS'(1);
					if (bulk_c == COUNT_BITS'(1)) begin
						phase_n = PH_BULK_CR;
					end
				end
				PH_LINE_LF, PH_BULK_LF: begin
					if (data_s1 != CH_LF) begin
						ev       = EV_ERROR;
						res_code = E_TOKEN;
					end else if ((ph_c == PH_LINE_LF) && (kind_c == K_BULK)) begin
						bulk_n  = acc_c[COUNT_BITS-1:0];
						phase_n = (acc_c == 64'd0) ? PH_BULK_CR : PH_BULK_DATA;
					end else if ((ph_c == PH_LINE_LF) && (kind_c == K_ARRAY) &&
					             (acc_c != 64'd0)) begin
						if (stk_stat.full) begin
							ev       = EV_ERROR;
							res_code = E_DEEP;
						end else begin
							stk_cmd.push = 1'b1;
							ev           = EV_VALUE;
							res_number   = acc_c;
							phase_n      = PH_MARK;
						end
					end else begin
						ev = EV_VALUE;
						if (kind_c == K_INT) begin
							res_number = neg_c ? (64'd0 - acc_c) : acc_c;
						end else if ((kind_c == K_BULK) || (kind_c == K_ARRAY)) begin
							res_number = acc_c;
						end
						// hand the finished value to the enclosing arrays
						stk_cmd.close = 1'b1;
						res_done      = stk_stat.empty_close;
						phase_n       = stk_stat.empty_close ? PH_DONE : PH_MARK;
					end
				end
				PH_DONE: begin
					ev = EV_IGNORE;
				end
				default: begin
					ev = EV_IGNORE;
				end
			endcase
			if (ev == EV_ERROR) begin
				err_n   = 1'b1;
				ecode_n = res_code;
			end
		end

		res_kind = ((ev == EV_FRAME) || (ev == EV_DATA) || (ev == EV_VALUE)) ? kind_n : K_INT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARK;
		end else if (adv) begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= K_INT;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			dig_q   <= 1'b0;
			bulk_q  <= '0;
			off_q   <= '0;
			err_q   <= 1'b0;
			ecode_q <= E_NONE;
		end else if (adv) begin
			kind_q  <= kind_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			dig_q   <= dig_n;
			bulk_q  <= bulk_n;
			off_q   <= off_c + 32'd1;
			err_q   <= err_n;
			ecode_q <= ecode_n;
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s2      <= ev;
			kind_s2    <= res_kind;
			code_s2    <= res_code;
			payload_s2 <= res_payload;
			number_s2  <= res_number;
			depth_s2   <= 5'(stk_depth);
			done_s2    <= res_done;
			off_s2     <= off_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {off_s2, code_s2, depth_s2, number_s2, payload_s2};
	assign m_tuser  = {kind_s2, ev_s2};
	assign m_tlast  = done_s2;

`ifndef SYNTH
	a_last_is_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser[2:0] == EV_VALUE))
		else $error("message end flagged on an item that finishes no value");

	a_error_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && err_q && !start_s1) |=> (m_tuser[2:0] == EV_IGNORE))
		else $error("byte after a latched error was not ignored");

	a_done_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (phase_q == PH_DONE) && !err_q && !start_s1) |=>
		((m_tuser[2:0] == EV_IGNORE) && !m_tlast))
		else $error("byte after a complete message was not ignored");

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input refused without a stalled result");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for resp_stream_parser: feeds RESP bytes, predicts each result item.
// Depends on rsp_pkg and the resp_stream_parser top level only.
module testbench;
	import rsp_pkg::*;

	localparam int DEPTH_LIM = MAX_DEPTH_DEF;
	localparam int CNT_BITS  = COUNT_BITS_DEF;
	localparam logic [63:0] CNT_MAX = (64'd1 << CNT_BITS) - 64'd1;
	localparam int HOLD_CYCLES = 80;

	typedef logic [7:0] byte_q_t[$];

	// one classified byte, as the block reports it
	typedef struct {
		logic [2:0]  ev;
		logic [2:0]  kind;
		logic [7:0]  payload;
		logic [63:0] number;
		logic [4:0]  depth;
		logic        done;
		logic [2:0]  ecode;
		logic [31:0] offset;
	} parse_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] data_byte
	logic [0:0]   s_tuser;   // [0] start_req
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;   // [7:0] payload, [71:8] number, [76:72] depth,
	                         // [79:77] error_code, [111:80] offset
	logic [5:0]   m_tuser;   // [2:0] event_res, [5:3] kind
	logic         m_tlast;   // message_done

	resp_stream_parser #(
		.MAX_DEPTH  (DEPTH_LIM),
		.COUNT_BITS (CNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	parse_result_t expected_events[$];
	int  fail_count = 0;
	bit  idle_on    = 1'b1;   // random gaps on both sides
	bit  hold_req   = 1'b0;   // ask the receiver for one long hold-off

	// Parser state as the testbench sees it
	phase_t              phase;
	logic [2:0]          cur_kind;
	logic [63:0]         accum;
	logic                negative;
	logic                digit_seen;
	logic [63:0]         bulk_left;
	logic [CNT_BITS-1:0] count_stack [DEPTH_LIM];
	logic [5:0]          stack_ptr;
	logic [31:0]         byte_offset;
	logic                err_latched;
	logic [2:0]          err_code;

	function automatic void clear_parse();
		phase       = PH_MARK;
		cur_kind    = K_INT;
		accum       = '0;
		negative    = 1'b0;
		digit_seen  = 1'b0;
		bulk_left   = '0;
		stack_ptr   = '0;
		byte_offset = '0;
		err_latched = 1'b0;
		err_code    = E_NONE;
		for (int i = 0; i < DEPTH_LIM; i++)
			count_stack[i] = '0;
	endfunction

	// A value has finished: take one element from each enclosing array, popping
	// every array that runs out. Return 1 when the top-level value is complete.
	function automatic logic close_value();
		while (stack_ptr != 0 && count_stack[stack_ptr - 1] == 1)
			stack_ptr = stack_ptr - 6'd1;
		if (stack_ptr == 0) begin
			phase = PH_DONE;
			return 1'b1;
		end
		count_stack[stack_ptr - 1] = count_stack[stack_ptr - 1] - CNT_BITS'(1);
		phase = PH_MARK;
		return 1'b0;
	endfunction

	// Advance the predicted parse by one accepted byte and return its classification.
	function automatic parse_result_t parse_byte(input logic [7:0] b, input logic st);
		parse_result_t r;
		logic [63:0]   lim;
		logic [63:0]   d;
		logic          digit;
		r.ev      = EV_FRAME;
		r.kind    = K_INT;
		r.payload = '0;
		r.number  = '0;
		r.done    = 1'b0;
		r.ecode   = E_NONE;
		if (st)
			clear_parse();
		r.depth     = stack_ptr[4:0];
		r.offset    = byte_offset;
		byte_offset = byte_offset + 32'd1;
		digit = (b >= CH_ZERO) && (b <= CH_NINE);
		d     = 64'(b) - 64'(CH_ZERO);

		if (err_latched) begin
			r.ev    = EV_IGNORE;
			r.ecode = err_code;
		end else begin
			case (phase)
				PH_MARK: begin
					accum      = '0;
					negative   = 1'b0;
					digit_seen = 1'b0;
					case (b)
						CH_COLON:  begin cur_kind = K_INT;   phase = PH_INT_START; end
						CH_PLUS:   begin cur_kind = K_STR;   phase = PH_STR;       end
						CH_MINUS:  begin cur_kind = K_ERR;   phase = PH_STR;       end
						CH_DOLLAR: begin cur_kind = K_BULK;  phase = PH_COUNT;     end
						CH_USCORE: begin cur_kind = K_NULL;  phase = PH_NUL_CR;    end
						CH_STAR:   begin cur_kind = K_ARRAY; phase = PH_COUNT;     end
						default: begin
							r.ev    = EV_ERROR;
							r.ecode = E_MARKER;
						end
					endcase
				end
				PH_INT_START, PH_INT_BODY: begin
					if (phase == PH_INT_START && (b == CH_PLUS || b == CH_MINUS)) begin
						negative = (b == CH_MINUS);
						phase    = PH_INT_BODY;
					end else if (digit) begin
						// saturate the magnitude, keep swallowing digits
						lim = negative ? INT_NEG_LIM : INT_POS_LIM;
						accum = (accum > (lim - d) / 64'd10) ? lim : accum * 64'd10 + d;
						digit_seen = 1'b1;
						phase      = PH_INT_BODY;
					end else if (b == CH_CR && (phase == PH_INT_START || digit_seen)) begin
						phase = PH_LINE_LF;
					end else begin
						r.ev    = EV_ERROR;
						r.ecode = E_TOKEN;
					end
				end
				PH_COUNT: begin
					if (digit) begin
						if (accum > (CNT_MAX - d) / 64'd10) begin
							r.ev    = EV_ERROR;
							r.ecode = E_OVERFLOW;
						end else begin
							accum = accum * 64'd10 + d;
						end
					end else if (b == CH_CR) begin
						phase = PH_LINE_LF;
					end else begin
						r.ev    = EV_ERROR;
						r.ecode = E_TOKEN;
					end
				end
				PH_STR: begin
					if (b == CH_CR) begin
						phase = PH_LINE_LF;
					end else if (b == CH_LF) begin
						r.ev    = EV_ERROR;
						r.ecode = E_TOKEN;
					end else begin
						r.ev      = EV_DATA;
						r.payload = b;
					end
				end
				PH_NUL_CR, PH_BULK_CR: begin
					if (b == CH_CR) begin
						phase = (phase == PH_NUL_CR) ? PH_LINE_LF : PH_BULK_LF;
					end else begin
						r.ev    = EV_ERROR;
						r.ecode = E_TOKEN;
					end
				end
				PH_BULK_DATA: begin
					r.ev      = EV_DATA;
					r.payload = b;
					bulk_left = bulk_left - 64'd1;
					if (bulk_left == 0)
						phase = PH_BULK_CR;
				end
				PH_LINE_LF, PH_BULK_LF: begin
					if (b != CH_LF) begin
						r.ev    = EV_ERROR;
						r.ecode = E_TOKEN;
					end else if (phase == PH_LINE_LF && cur_kind == K_BULK) begin
						// header done: payload follows, or straight to the closing CR
						bulk_left = accum;
						phase = (accum == 0) ? PH_BULK_CR : PH_BULK_DATA;
					end else if (phase == PH_LINE_LF && cur_kind == K_ARRAY && accum != 0) begin
						if (stack_ptr >= DEPTH_LIM) begin
							r.ev    = EV_ERROR;
							r.ecode = E_DEEP;
						end else begin
							count_stack[stack_ptr] = accum[CNT_BITS-1:0];
							stack_ptr = stack_ptr + 6'd1;
							r.ev      = EV_VALUE;
							r.number  = accum;
							phase     = PH_MARK;
						end
					end else begin
						r.ev = EV_VALUE;
						if (cur_kind == K_INT)
							r.number = negative ? 64'd0 - accum : accum;
						else if (cur_kind == K_BULK || cur_kind == K_ARRAY)
							r.number = accum;
						r.done = close_value();
					end
				end
				default: r.ev = EV_IGNORE;
			endcase
			if (r.ev == EV_ERROR) begin
				err_latched = 1'b1;
				err_code    = r.ecode;
			end
		end
		r.kind = (r.ev >= EV_FRAME && r.ev <= EV_VALUE) ? cur_kind : K_INT;
		return r;
	endfunction

	// Clock and the run limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare every result item with the oldest prediction
	always @(posedge clk) begin
		parse_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				$error("result item with no prediction waiting");
				fail_count++;
			end else begin
				w = expected_events.pop_front();
				check_field("event_res",    64'(w.ev),      64'(m_tuser[2:0]));
				check_field("kind",         64'(w.kind),    64'(m_tuser[5:3]));
				check_field("payload",      64'(w.payload), 64'(m_tdata[7:0]));
				check_field("number",       w.number,       m_tdata[71:8]);
				check_field("depth",        64'(w.depth),   64'(m_tdata[76:72]));
				check_field("error_code",   64'(w.ecode),   64'(m_tdata[79:77]));
				check_field("offset",       64'(w.offset),  64'(m_tdata[111:80]));
				check_field("message_done", 64'(w.done),    64'(m_tlast));
			end
		end
	end

	// Offer one byte from a falling edge, hold it until taken, then predict it
	task automatic send_byte(input logic [7:0] b, input logic st);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_events.push_back(parse_byte(b, st));
		@(negedge clk);
	endtask

	task automatic send_message(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == 0);
	endtask

	// Drop valid and hold until every predicted item has come back
	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_text(inout byte_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endtask

	task automatic add_line(inout byte_q_t q, input string s);
		add_text(q, s);
		q.push_back(CH_CR);
		q.push_back(CH_LF);
	endtask

	task automatic add_nest(inout byte_q_t q, input int levels);
		repeat (levels) add_line(q, "*1");
	endtask

	// Build one message with random content, mostly well-formed; arrays are expanded
	// iteratively, each open level holding the elements it still owes.
	task automatic build_message(output byte_q_t q, input int start_level);
		int   owed[$];
		int   k;
		int   n;
		logic [7:0] b;
		string s;
		q = {};
		owed.push_back(1);
		while (owed.size() != 0) begin
			if (owed[owed.size() - 1] == 0) begin
				owed.delete(owed.size() - 1);
			end else begin
				owed[owed.size() - 1] = owed[owed.size() - 1] - 1;
				k = $urandom_range(0, 19);
				if (k >= 15 && k <= 18 && start_level + owed.size() > 4)
					k = 13;
				if (k <= 3) begin
					// integer: sometimes long enough to saturate
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22)
					                                : $urandom_range(0, 4);
					s = ":";
					if (n != 0 && $urandom_range(0, 2) == 0)
						s = $urandom_range(0, 1) ? ":-" : ":+";
					add_text(q, s);
					repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					add_line(q, "");
				end else if (k <= 8) begin
					q.push_back(k <= 6 ? CH_PLUS : CH_MINUS);
					repeat ($urandom_range(0, 6)) begin
						b = 8'($urandom_range(0, 255));
						q.push_back((b == CH_CR || b == CH_LF) ? 8'h20 : b);
					end
					add_line(q, "");
				end else if (k <= 12) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					                                : $urandom_range(0, 5);
					add_line(q, $sformatf("$%0d", n));
					repeat (n) q.push_back(8'($urandom_range(0, 255)));
					add_line(q, "");
				end else if (k <= 14) begin
					add_line(q, "_");
				end else if (k <= 18) begin
					n = $urandom_range(0, 3);
					add_line(q, $sformatf("*%0d", n));
					if (n != 0)
						owed.push_back(n);
				end else begin
					// huge count: overflows, or leaves the array unfinished
					add_text(q, "*");
					repeat ($urandom_range(10, 11))
						q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					add_line(q, "");
				end
			end
		end
	endtask

	// Mostly well-formed messages, some corrupted or cut short, some with
	// trailing bytes that the block should ignore.
	task automatic run_random_messages(input int byte_goal);
		byte_q_t q;
		byte_q_t deep;
		int      sent;
		int      idx;
		sent = 0;
		while (sent < byte_goal) begin
			if ($urandom_range(0, 14) == 0) begin
				deep = {};
				add_nest(deep, $urandom_range(14, 17));
				build_message(q, 5);
				q = {deep, q};
			end else begin
				build_message(q, 0);
			end
			if ($urandom_range(0, 5) == 0) begin
				idx = $urandom_range(0, q.size() - 1);
				q[idx] = 8'($urandom_range(0, 255));
			end else if ($urandom_range(0, 9) == 0) begin
				idx = $urandom_range(1, q.size());
				while (q.size() > idx)
					q.delete(q.size() - 1);
			end
			send_message(q);
			sent += q.size();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic test_scalar_kinds();
		byte_q_t q;
		q = {}; add_line(q, ":42"); send_message(q);
		q = {}; add_line(q, "+OK"); send_message(q);
		q = {}; add_line(q, "-ERR x"); send_message(q);
		q = {}; add_line(q, "$3"); add_line(q, "abc"); send_message(q);
		q = {}; add_line(q, "$0"); add_line(q, ""); send_message(q);
		q = {}; add_line(q, "_"); send_message(q);
		q = {}; add_line(q, "*0"); send_message(q);
		q = {}; add_line(q, "*2"); add_line(q, ":1"); add_line(q, "+a"); send_message(q);
		wait_for_results();
	endtask

	task automatic test_integer_syntax();
		byte_q_t q;
		q = {}; add_line(q, ":"); send_message(q);
		q = {}; add_line(q, ":-"); send_message(q);
		q = {}; add_line(q, ": 1"); send_message(q);
		q = {}; add_line(q, ":+7"); send_message(q);
		q = {}; add_line(q, ":-0"); send_message(q);
		q = {}; add_line(q, ":1-"); send_message(q);
		// saturation either way, and the exact negative and positive limits
		q = {}; add_line(q, ":99999999999999999999"); send_message(q);
		q = {}; add_line(q, ":-99999999999999999999"); send_message(q);
		q = {}; add_line(q, ":-9223372036854775808"); send_message(q);
		q = {}; add_line(q, ":9223372036854775807"); send_message(q);
		wait_for_results();
	endtask

	task automatic test_counts();
		byte_q_t q;
		q = {}; add_line(q, "*4294967296"); send_message(q);
		q = {}; add_line(q, "$4294967295"); send_message(q);
		q = {}; add_line(q, "$"); add_line(q, ""); send_message(q);
		q = {}; add_line(q, "$-1"); send_message(q);
		q = {}; add_line(q, "*"); send_message(q);
		wait_for_results();
	endtask

	task automatic test_line_ends();
		byte_q_t q;
		q = {}; add_text(q, ":5"); q.push_back(CH_LF); send_message(q);
		q = {}; add_text(q, "+ab"); q.push_back(CH_LF); send_message(q);
		q = {}; add_text(q, ":5"); q.push_back(CH_CR); add_text(q, "X"); send_message(q);
		q = {}; add_line(q, "$2"); add_text(q, "abX"); send_message(q);
		q = {}; add_line(q, "$0"); q.push_back(CH_LF); send_message(q);
		q = {}; add_text(q, "_x"); send_message(q);
		q = {}; add_text(q, "*1"); q.push_back(CH_CR); q.push_back(CH_CR); send_message(q);
		wait_for_results();
	endtask

	task automatic test_unknown_markers();
		byte_q_t q;
		q = {8'h3F}; send_message(q);
		q = {8'h00}; send_message(q);
		q = {8'hFF}; send_message(q);
		q = {CH_CR}; send_message(q);
		q = {}; add_line(q, "*1"); q.push_back(CH_LF); send_message(q);
		wait_for_results();
	endtask

	task automatic test_nesting();
		byte_q_t q;
		// full depth closes in one go; one more level is too deep
		q = {}; add_nest(q, DEPTH_LIM); add_line(q, ":1"); send_message(q);
		q = {}; add_nest(q, DEPTH_LIM + 1); add_line(q, ":1"); send_message(q);
		q = {};
		add_line(q, "*2"); add_line(q, "*1"); add_line(q, ":-3");
		add_line(q, "*2"); add_line(q, "_"); add_line(q, "+");
		send_message(q);
		wait_for_results();
	endtask

	task automatic test_ignored_bytes();
		byte_q_t q;
		// bytes past a complete message, then past a latched error
		q = {}; add_line(q, ":7"); send_message(q);
		send_byte(CH_COLON, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		q = {8'h3F}; send_message(q);
		send_byte(CH_PLUS, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		// restart in the middle of a partial message
		q = {}; add_text(q, "$5"); send_message(q);
		q = {}; add_line(q, "+fresh"); send_message(q);
		wait_for_results();
	endtask

	task automatic test_output_stall();
		// keep offering while the receiver holds off, so the input stalls
		hold_req = 1'b1;
		run_random_messages(16);
		wait_for_results();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		clear_parse();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_scalar_kinds();
		test_integer_syntax();
		test_counts();
		test_line_ends();
		test_unknown_markers();
		test_nesting();
		test_ignored_bytes();
		test_output_stall();
		// closing stretch at full rate on both sides
		idle_on = 1'b0;
		run_random_messages(30);
		wait_for_results();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && expected_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
